// File: sv/prl_pkg.sv
// shared types, codes and constants of the positional record list
`default_nettype none

package prl_pkg;

	localparam int PRL_DEPTH = 16;

	// request kinds
	typedef enum logic [2:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_BACK  = 3'd1,
		KIND_INS_AT    = 3'd2,
		KIND_REM_FRONT = 3'd3,
		KIND_REM_BACK  = 3'd4,
		KIND_REM_AT    = 3'd5,
		KIND_SEARCH    = 3'd6
	} kind_e;

	// result status codes
	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_FULL   = 3'd1,
		STAT_EMPTY  = 3'd2,
		STAT_BADPOS = 3'd3,
		STAT_NOKEY  = 3'd4
	} status_e;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} fsm_e;

	// what every cell does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_SEARCH_LOAD,
		CELL_SEARCH_SHIFT
	} cell_op_e;

	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [55:0]        name_high;
	} rec_t;

	// broadcast command: operation plus the new record or the searched key
	typedef struct packed {
		cell_op_e op;
		rec_t     rec;
	} cell_cmd_t;

	// search result moving down the chain towards cell 0
	typedef struct packed {
		logic        hit;
		logic [63:0] name_low;
		logic [55:0] name_high;
	} hit_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [4:0]         position;
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [55:0]        name_high;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  found_index;
		logic [63:0] found_name_low;
		logic [55:0] found_name_high;
		logic [4:0]  record_count;
	} rsp_t;

endpackage

`default_nettype wire

// File: sv/prl_stream_if.sv
// valid/ready stream interface carrying one payload per beat
`default_nettype none

interface prl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/prl_cell.sv
// one list cell: a record slot plus a search result slot
`default_nettype none

module prl_cell import prl_pkg::*; #(
	parameter int DEPTH = PRL_DEPTH,
	parameter int IDX   = 0
) (
	input  logic                         clk,
	input  cell_cmd_t                    cmd,
	input  logic [$clog2(DEPTH+1)-1:0]   pos,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  rec_t                         left_rec,
	input  rec_t                         right_rec,
	input  hit_t                         right_res,
	input  logic [$clog2(DEPTH)-1:0]     right_idx,
	output rec_t                         rec,
	output hit_t                         res,
	output logic [$clog2(DEPTH)-1:0]     idx
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [IW-1:0] IDX_I = IW'(IDX);

	rec_t            rec_q, rec_d;
	hit_t            res_q, res_d;
	logic [IW-1:0]   idx_q, idx_d;

	// next contents of the slot and of the search slot
	always_comb begin
		rec_d = rec_q;
		res_d = res_q;
		idx_d = idx_q;
		case (cmd.op)
			CELL_INSERT: begin
				if (IDX_C > pos) begin
					rec_d = left_rec;
				end else if (IDX_C == pos) begin
					rec_d = cmd.rec;
				end
			end
			CELL_REMOVE: begin
				if (IDX_C >= pos) begin
					rec_d = right_rec;
				end
			end
			CELL_SEARCH_LOAD: begin
				res_d.hit       = (IDX_C < count) && (rec_q.key == cmd.rec.key);
				res_d.name_low  = rec_q.name_low;
				res_d.name_high = rec_q.name_high;
				idx_d           = IDX_I;
			end
			CELL_SEARCH_SHIFT: begin
				if (!res_q.hit) begin
					res_d = right_res;
					idx_d = right_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		rec_q <= rec_d;
		res_q <= res_d;
		idx_q <= idx_d;
	end

	assign rec = rec_q;
	assign res = res_q;
	assign idx = idx_q;

endmodule

`default_nettype wire

// File: sv/prl_ctrl.sv
// request decode, record count, search sequencing and result register
`default_nettype none

module prl_ctrl import prl_pkg::*; #(
	parameter int DEPTH = PRL_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  req_t                         req_data,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output rsp_t                         rsp_data,
	output cell_cmd_t                    cmd,
	output logic [$clog2(DEPTH+1)-1:0]   pos,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	input  hit_t                         head_res,
	input  logic [$clog2(DEPTH)-1:0]     head_idx
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	fsm_e            state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   step_q, step_d;
	logic            out_v_q, out_v_d;
	rsp_t            out_q, out_d;
	logic            accept;
	logic            full, empty;
	logic [CMPW-1:0] posx, cntx;
	logic            done;

	assign req_ready = (state_q == S_IDLE) && (!out_v_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == FULL_C);
	assign empty     = (count_q == '0);
	assign posx      = CMPW'(req_data.position);
	assign cntx      = CMPW'(count_q);
	// first hit found, or every live cell has been looked at
	assign done      = head_res.hit || ((CW'(step_q) + CW'(1)) >= count_q);

	// next state, cell command and result
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		step_d      = step_q;
		out_v_d     = out_v_q && !rsp_ready;
		out_d       = out_q;
		cmd.op      = CELL_HOLD;
		cmd.rec.key       = req_data.key;
		cmd.rec.name_low  = req_data.name_low;
		cmd.rec.name_high = req_data.name_high;
		pos         = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_d.status          = STAT_OK;
					out_d.found_index     = '0;
					out_d.found_name_low  = '0;
					out_d.found_name_high = '0;
					case (req_data.kind)
						KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
							if (full) begin
								out_d.status = STAT_FULL;
							end else if (req_data.kind == KIND_INS_AT && posx > cntx) begin
								out_d.status = STAT_BADPOS;
							end else begin
								cmd.op  = CELL_INSERT;
								count_d = count_q + CW'(1);
								if (req_data.kind == KIND_INS_BACK) begin
									pos = count_q;
								end else if (req_data.kind == KIND_INS_AT) begin
									pos = CW'(req_data.position);
								end
							end
						end
						KIND_REM_FRONT, KIND_REM_BACK, KIND_REM_AT: begin
							if (empty) begin
								out_d.status = STAT_EMPTY;
							end else if (req_data.kind == KIND_REM_AT && posx >= cntx) begin
								out_d.status = STAT_BADPOS;
							end else begin
								cmd.op  = CELL_REMOVE;
								count_d = count_q - CW'(1);
								if (req_data.kind == KIND_REM_BACK) begin
									pos = count_q - CW'(1);
								end else if (req_data.kind == KIND_REM_AT) begin
									pos = CW'(req_data.position);
								end
							end
						end
						KIND_SEARCH: begin
							cmd.op  = CELL_SEARCH_LOAD;
							step_d  = '0;
							state_d = S_SEARCH;
						end
						default: begin
						end
					endcase
					out_d.record_count = 5'(count_d);
					out_v_d            = (req_data.kind != KIND_SEARCH);
				end
			end
			S_SEARCH: begin
				if (done) begin
					state_d            = S_IDLE;
					out_v_d            = 1'b1;
					out_d.record_count = 5'(count_q);
					if (head_res.hit) begin
						out_d.status          = STAT_OK;
						out_d.found_index     = 4'(head_idx);
						out_d.found_name_low  = head_res.name_low;
						out_d.found_name_high = head_res.name_high;
					end else begin
						out_d.status          = STAT_NOKEY;
						out_d.found_index     = '0;
						out_d.found_name_low  = '0;
						out_d.found_name_high = '0;
					end
				end else begin
					cmd.op = CELL_SEARCH_SHIFT;
					step_d = step_q + IW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			out_v_q <= out_v_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		step_q <= step_d;
		out_q  <= out_d;
	end

	assign rsp_valid = out_v_q;
	assign rsp_data  = out_q;
	assign count     = count_q;

endmodule

`default_nettype wire

// File: sv/positional_record_list_core.sv
// top level: controller and the row of record cells
//
//  channel | dir | payload | beat taken when
//  req     | in  | req_t   | req.valid & req.ready
//  rsp     | out | rsp_t   | rsp.valid & rsp.ready
//
// inserts, removes and unknown kinds finish on the request beat: cells shift their
// records one place in parallel and the result is registered at once.
// a search loads every cell's search slot on the request beat, then the
// first matching record walks one cell per cycle towards cell 0.
// reset clears the count and the handshake state only; slots hold garbage.
// a request is taken only when idle and the result register is free or
// being emptied in the same cycle.
`default_nettype none

module positional_record_list_core import prl_pkg::*; #(
	parameter int DEPTH = PRL_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	prl_stream_if.sink   req,
	prl_stream_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	cell_cmd_t     cmd;
	logic [CW-1:0] pos;
	logic [CW-1:0] count;
	req_t          req_pl;
	rsp_t          rsp_pl;
	rec_t          rec_w [DEPTH];
	hit_t          res_w [DEPTH];
	logic [IW-1:0] idx_w [DEPTH];

	assign req_pl   = req.data;
	assign rsp.data = rsp_pl;

	prl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_data (req_pl),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data (rsp_pl),
		.cmd      (cmd),
		.pos      (pos),
		.count    (count),
		.head_res (res_w[0]),
		.head_idx (idx_w[0])
	);

	// row of cells, each linked to both neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rec_t          left_rec;
		rec_t          right_rec;
		hit_t          right_res;
		logic [IW-1:0] right_idx;

		if (i == 0) begin : g_first
			assign left_rec = cmd.rec;
		end else begin : g_mid
			assign left_rec = rec_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_rec = rec_w[i];
			assign right_res = '0;
			assign right_idx = '0;
		end else begin : g_inner
			assign right_rec = rec_w[i+1];
			assign right_res = res_w[i+1];
			assign right_idx = idx_w[i+1];
		end

		prl_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.pos      (pos),
			.count    (count),
			.left_rec (left_rec),
			.right_rec(right_rec),
			.right_res(right_res),
			.right_idx(right_idx),
			.rec      (rec_w[i]),
			.res      (res_w[i]),
			.idx      (idx_w[i])
		);
	end

endmodule

`default_nettype wire

// File: sv/prl_checker.sv
// port-level checks on the record list, bound to the top level
`default_nettype none

module prl_checker import prl_pkg::*; #(
	parameter int DEPTH = PRL_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// a stalled result beat holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat changed while stalled");

	// no new request while an old result still waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result blocked");

	// search fields are zero unless the status is ok
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status != STAT_OK) |->
			(rsp_data.found_index == '0) && (rsp_data.found_name_low == '0) &&
			(rsp_data.found_name_high == '0))
		else $error("search fields set on a failed request");

	// record count within the list size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH > 31) || (32'(rsp_data.record_count) <= 32'(DEPTH)))
		else $error("record count above list size");

	// status code is one of the defined ones
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == STAT_OK) || (rsp_data.status == STAT_FULL) ||
			(rsp_data.status == STAT_EMPTY) || (rsp_data.status == STAT_BADPOS) ||
			(rsp_data.status == STAT_NOKEY))
		else $error("undefined status code");

endmodule

bind positional_record_list_core prl_checker #(
	.DEPTH(DEPTH)
) u_prl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

`default_nettype wire
